>>> rtl/core/idc_pkg.sv
package idc_pkg;

  localparam int unsigned IDC_YEAR_W  = 14;
  localparam int unsigned IDC_MONTH_W = 4;
  localparam int unsigned IDC_DAY_W   = 5;
  localparam int unsigned IDC_COUNT_W = 22;
  localparam int unsigned IDC_Q100_W  = 8;

  localparam int unsigned IDC_QUEUE_DEPTH = 4;

  localparam logic [IDC_YEAR_W-1:0]  IDC_YEAR_MAX  = 14'd9999;
  localparam logic [IDC_MONTH_W-1:0] IDC_MONTH_MAX = 4'd12;
  localparam logic [IDC_MONTH_W-1:0] IDC_FEBRUARY  = 4'd2;
  localparam logic [IDC_DAY_W-1:0]   IDC_LEAP_FEB  = 5'd29;
  localparam logic [8:0]             IDC_DAYS_YEAR = 9'd365;
  localparam logic [6:0]             IDC_CENTURY   = 7'd100;

  // floor(v / 100) for any 14-bit v is (v * 5243) >> 19 exactly.
  localparam logic [12:0]            IDC_RECIP_100 = 13'd5243;
  localparam int unsigned            IDC_RECIP_SH  = 19;

  localparam logic [IDC_DAY_W-1:0] IDC_MONTH_LEN [12] =
    '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  localparam logic [8:0] IDC_DAYS_BEFORE [12] =
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

  typedef struct packed {
    logic [IDC_YEAR_W-1:0]  year;
    logic [IDC_MONTH_W-1:0] month;
    logic [IDC_DAY_W-1:0]   day;
  } date_t;

  // What the back end needs of one date to build its ordinal.
  typedef struct packed {
    logic [IDC_YEAR_W-1:0]  prev_year;
    logic [IDC_Q100_W-1:0]  prev_q100;
    logic [IDC_MONTH_W-1:0] month;
    logic [IDC_DAY_W-1:0]   day;
    logic                   leap;
  } ord_arg_t;

  typedef struct packed {
    logic     bad;
    ord_arg_t first;
    ord_arg_t last;
  } cls_item_t;

  function automatic logic [IDC_Q100_W-1:0] idc_div100(input logic [IDC_YEAR_W-1:0] v);
    logic [26:0] prod;
    prod = 27'(v) * 27'(IDC_RECIP_100);
    return prod[26:IDC_RECIP_SH];
  endfunction

  function automatic logic [3:0] idc_month_idx(input logic [IDC_MONTH_W-1:0] m);
    logic [3:0] idx;
    idx = 4'd0;
    if (m >= 4'd1 && m <= IDC_MONTH_MAX) idx = m - 4'd1;
    return idx;
  endfunction

  function automatic logic [IDC_DAY_W-1:0] idc_month_len(input logic [IDC_MONTH_W-1:0] m,
                                                         input logic leap);
    logic [IDC_DAY_W-1:0] len;
    len = IDC_MONTH_LEN[idc_month_idx(m)];
    if (m == IDC_FEBRUARY && leap) len = IDC_LEAP_FEB;
    return len;
  endfunction

  function automatic logic [8:0] idc_days_before(input logic [IDC_MONTH_W-1:0] m);
    return IDC_DAYS_BEFORE[idc_month_idx(m)];
  endfunction

endpackage

>>> rtl/core/idc_if.sv
interface idc_in_if import idc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IDC_YEAR_W-1:0]  start_year;
  logic [IDC_MONTH_W-1:0] start_month;
  logic [IDC_DAY_W-1:0]   start_day;
  logic [IDC_YEAR_W-1:0]  end_year;
  logic [IDC_MONTH_W-1:0] end_month;
  logic [IDC_DAY_W-1:0]   end_day;

  modport source (output valid, start_year, start_month, start_day,
                  end_year, end_month, end_day, input ready);
  modport sink   (input valid, start_year, start_month, start_day,
                  end_year, end_month, end_day, output ready);
endinterface

interface idc_out_if import idc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IDC_COUNT_W-1:0] day_count;
  logic                   invalid;

  modport source (output valid, day_count, invalid, input ready);
  modport sink   (input valid, day_count, invalid, output ready);
endinterface

>>> rtl/core/inclusive_day_count_top.sv
// Channel  Dir  Payload                                           Handshake
// in_ch    in   start_year/month/day, end_year/month/day          valid/ready
// out_ch   out  day_count (22 bits), invalid                      valid/ready
//
// One request per cycle is sustained while out_ch.ready holds. A request passes
// an input register, a front stage for the quotients by 100 (the date checks
// follow it), the queue, and three back stages (item register, ordinal sums,
// subtraction into the output register).
// Synchronous active-low reset empties every stage and the queue.
// A stalled output fills the back stages, the queue between front and back
// absorbs the front's work, and only then does in_ch.ready fall.
module inclusive_day_count_top import idc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = IDC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  idc_in_if.sink     in_ch,
  idc_out_if.source  out_ch
);

  logic      push_valid;
  logic      push_ready;
  cls_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  cls_item_t pop_item;

  idc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cls_valid (push_valid),
    .cls_ready (push_ready),
    .cls_item  (push_item)
  );

  idc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  idc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (pop_valid),
    .cls_ready (pop_ready),
    .cls_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/core/idc_front.sv
module idc_front import idc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  idc_in_if.sink       in_ch,
  output logic         cls_valid,
  input  logic         cls_ready,
  output cls_item_t    cls_item
);

  typedef struct packed {
    logic [IDC_YEAR_W-1:0]  year;
    logic [IDC_YEAR_W-1:0]  prev_year;
    logic [IDC_Q100_W-1:0]  q100;
    logic [IDC_Q100_W-1:0]  prev_q100;
    logic [IDC_MONTH_W-1:0] month;
    logic [IDC_DAY_W-1:0]   day;
  } split_t;

  logic   a_v_r;
  date_t  a_date_r [2];
  logic   b_v_r;
  split_t b_split_r [2];

  logic   a_take;
  logic   b_take;
  split_t b_split_nxt [2];
  logic   date_ok [2];
  logic   leap [2];

  assign b_take       = !b_v_r || cls_ready;
  assign a_take       = !a_v_r || b_take;
  assign in_ch.ready  = a_take;

  // Quotients by 100 of the year and of the year before it.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      b_split_nxt[i].year      = a_date_r[i].year;
      b_split_nxt[i].prev_year = a_date_r[i].year - 14'd1;
      b_split_nxt[i].q100      = idc_div100(a_date_r[i].year);
      b_split_nxt[i].prev_q100 = idc_div100(a_date_r[i].year - 14'd1);
      b_split_nxt[i].month     = a_date_r[i].month;
      b_split_nxt[i].day       = a_date_r[i].day;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_take) a_v_r <= in_ch.valid;
      if (b_take) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && in_ch.valid) begin
      a_date_r[0] <= '{year: in_ch.start_year, month: in_ch.start_month,
                       day: in_ch.start_day};
      a_date_r[1] <= '{year: in_ch.end_year, month: in_ch.end_month,
                       day: in_ch.end_day};
    end
    if (b_take && a_v_r) begin
      b_split_r <= b_split_nxt;
    end
  end

  // Leap years: divisible by four, and not a century unless the century
  // count is itself divisible by four.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [IDC_YEAR_W-1:0] rem100;
      rem100  = b_split_r[i].year -
                (14'(b_split_r[i].q100) * 14'(IDC_CENTURY));
      leap[i] = (b_split_r[i].year[1:0] == 2'd0) &&
                ((rem100 != 14'd0) || (b_split_r[i].q100[1:0] == 2'd0));
      date_ok[i] = (b_split_r[i].year >= 14'd1) && (b_split_r[i].year <= IDC_YEAR_MAX) &&
                   (b_split_r[i].month inside {[4'd1:IDC_MONTH_MAX]}) &&
                   (b_split_r[i].day >= 5'd1) &&
                   (b_split_r[i].day <= idc_month_len(b_split_r[i].month, leap[i]));
    end
  end

  assign cls_valid            = b_v_r;
  assign cls_item.bad         = !date_ok[0] || !date_ok[1];
  assign cls_item.first       = '{prev_year: b_split_r[0].prev_year,
                                  prev_q100: b_split_r[0].prev_q100,
                                  month: b_split_r[0].month,
                                  day: b_split_r[0].day, leap: leap[0]};
  assign cls_item.last        = '{prev_year: b_split_r[1].prev_year,
                                  prev_q100: b_split_r[1].prev_q100,
                                  month: b_split_r[1].month,
                                  day: b_split_r[1].day, leap: leap[1]};

endmodule

>>> rtl/core/idc_fifo.sv
module idc_fifo import idc_pkg::*; #(
  parameter int unsigned DEPTH = IDC_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  cls_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output cls_item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cls_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on a lone push");

  a_pop_only_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not shrink on a lone pop");

endmodule

>>> rtl/core/idc_back.sv
module idc_back import idc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cls_valid,
  output logic      cls_ready,
  input  cls_item_t cls_item,
  idc_out_if.source out_ch
);

  logic                   c_v_r;
  cls_item_t              c_item_r;
  logic                   d_v_r;
  logic                   d_bad_r;
  logic [IDC_COUNT_W-1:0] d_ord_r [2];
  logic                   o_v_r;
  logic [IDC_COUNT_W-1:0] o_count_r;
  logic                   o_invalid_r;

  logic                   c_take;
  logic                   d_take;
  logic                   o_take;
  logic [IDC_COUNT_W-1:0] ord_nxt [2];
  logic [IDC_COUNT_W-1:0] count_nxt;
  logic                   invalid_nxt;

  assign o_take    = !o_v_r || out_ch.ready;
  assign d_take    = !d_v_r || o_take;
  assign c_take    = !c_v_r || d_take;
  assign cls_ready = c_take;

  // Ordinal day number, 0001-01-01 being day one. Malformed dates give
  // some value that is never used.
  function automatic logic [IDC_COUNT_W-1:0] ordinal(input ord_arg_t a);
    logic [IDC_COUNT_W-1:0] whole_years;
    logic [IDC_COUNT_W-1:0] in_year;
    whole_years = 22'(a.prev_year) * 22'(IDC_DAYS_YEAR)
                + 22'(a.prev_year[IDC_YEAR_W-1:2])
                - 22'(a.prev_q100)
                + 22'(a.prev_q100[IDC_Q100_W-1:2]);
    in_year     = 22'(idc_days_before(a.month))
                + 22'(a.leap && (a.month > IDC_FEBRUARY))
                + 22'(a.day);
    return whole_years + in_year;
  endfunction

  assign ord_nxt[0] = ordinal(c_item_r.first);
  assign ord_nxt[1] = ordinal(c_item_r.last);

  always_comb begin
    invalid_nxt = d_bad_r || (d_ord_r[1] < d_ord_r[0]);
    count_nxt   = invalid_nxt ? '0 : (d_ord_r[1] - d_ord_r[0] + 22'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (c_take) c_v_r <= cls_valid;
      if (d_take) d_v_r <= c_v_r;
      if (o_take) o_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_take && cls_valid) c_item_r <= cls_item;
    if (d_take && c_v_r) begin
      d_ord_r <= ord_nxt;
      d_bad_r <= c_item_r.bad;
    end
    if (o_take && d_v_r) begin
      o_count_r   <= count_nxt;
      o_invalid_r <= invalid_nxt;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.day_count = o_count_r;
  assign out_ch.invalid   = o_invalid_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_invalid_r) |-> (o_count_r == '0))
    else $error("flagged request carries a non-zero count");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !o_invalid_r) |-> (o_count_r != '0))
    else $error("accepted date pair produced a zero count");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import idc_pkg::*;

  localparam int unsigned YEAR_LAST    = 9999;
  localparam int unsigned RANDOM_PAIRS = 500;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    date_t first;
    date_t last;
  } date_pair_t;

  typedef struct {
    logic [IDC_COUNT_W-1:0] count;
    logic                   invalid;
  } day_result_t;

  logic clk;
  logic rst_n;

  idc_in_if  in_ch ();
  idc_out_if out_ch ();

  inclusive_day_count_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_pair_t  pending_pairs[$];
  day_result_t expected_counts[$];
  date_pair_t  in_flight;
  date_pair_t  next_pair;
  day_result_t wanted;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  bit          hold_done;
  logic [15:0] rx_cycle;
  int          n_accepted = 0;
  int          n_errors   = 0;
  int          cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the expected counts
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      2:           return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Day number counted from 1 January of year 1; returns 0 for a malformed date.
  function automatic bit date_ordinal(input date_t dt, output int unsigned ord);
    int unsigned y, m, d, p, i;
    y   = dt.year;
    m   = dt.month;
    d   = dt.day;
    ord = 0;
    if (y < 1 || y > YEAR_LAST || m < 1 || m > 12) return 1'b0;
    if (d < 1 || d > month_days(y, m)) return 1'b0;
    p   = y - 1;
    ord = 365 * p + p / 4 - p / 100 + p / 400;
    for (i = 1; i < m; i++) ord += month_days(y, i);
    ord += d;
    return 1'b1;
  endfunction

  function automatic day_result_t predict_span(input date_pair_t p);
    int unsigned a, b;
    bit          ok_a, ok_b;
    day_result_t r;
    ok_a = date_ordinal(p.first, a);
    ok_b = date_ordinal(p.last, b);
    if (!ok_a || !ok_b || b < a) begin
      r.count   = '0;
      r.invalid = 1'b1;
    end else begin
      r.count   = IDC_COUNT_W'(b - a + 1);
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void push_pair(input int sy, input int sm, input int sd,
                                    input int ey, input int em, input int ed);
    date_pair_t p;
    p.first.year  = IDC_YEAR_W'(sy);
    p.first.month = IDC_MONTH_W'(sm);
    p.first.day   = IDC_DAY_W'(sd);
    p.last.year   = IDC_YEAR_W'(ey);
    p.last.month  = IDC_MONTH_W'(em);
    p.last.day    = IDC_DAY_W'(ed);
    pending_pairs.push_back(p);
  endfunction

  // Century and quad-century years are favoured so that the leap rule is exercised.
  function automatic int unsigned pick_year();
    case ($urandom_range(0, 9))
      0:       return 100 * $urandom_range(1, 99);
      1:       return 400 * $urandom_range(1, 24);
      2:       return ($urandom_range(0, 1) != 0) ? 1 : YEAR_LAST;
      default: return $urandom_range(1, YEAR_LAST);
    endcase
  endfunction

  function automatic date_t date_in_year(input int unsigned y);
    date_t       dt;
    int unsigned m, d;
    m = $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) m = 2;
    d = $urandom_range(1, month_days(y, m));
    if ($urandom_range(0, 7) == 0) d = month_days(y, m);
    dt.year  = IDC_YEAR_W'(y);
    dt.month = IDC_MONTH_W'(m);
    dt.day   = IDC_DAY_W'(d);
    return dt;
  endfunction

  function automatic date_t malform(input date_t dt);
    int unsigned len;
    case ($urandom_range(0, 2))
      0: dt.year  = ($urandom_range(0, 1) != 0) ? '0 : IDC_YEAR_W'($urandom_range(10000, 16383));
      1: dt.month = ($urandom_range(0, 1) != 0) ? '0 : IDC_MONTH_W'($urandom_range(13, 15));
      default: begin
        len = month_days(dt.year, dt.month);
        if (len == 31 || $urandom_range(0, 2) == 0) dt.day = '0;
        else dt.day = IDC_DAY_W'($urandom_range(len + 1, 31));
      end
    endcase
    return dt;
  endfunction

  function automatic date_pair_t in_order(input date_pair_t p);
    int unsigned a, b;
    date_t       tmp;
    void'(date_ordinal(p.first, a));
    void'(date_ordinal(p.last, b));
    if (b < a) begin
      tmp     = p.first;
      p.first = p.last;
      p.last  = tmp;
    end
    return p;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int unsigned k;
    k       = $urandom_range(0, 99);
    p.first = date_in_year(pick_year());
    p.last  = date_in_year(pick_year());
    if (k < 55) begin
      p = in_order(p);
    end else if (k < 70) begin
      // Short spans within one year or across a single new year.
      p.last = date_in_year((p.first.year < YEAR_LAST && $urandom_range(0, 1) != 0) ?
                            p.first.year + 1 : p.first.year);
      p = in_order(p);
    end else if (k < 80) begin
      // Left in whatever order they came, so about half end before they start.
    end else if (k < 90) begin
      if ($urandom_range(0, 1) != 0) p.first = malform(p.first);
      else p.last = malform(p.last);
    end else begin
      p = date_pair_t'({$urandom, $urandom});
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_counts.push_back(predict_span(in_flight));
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          next_pair         = pending_pairs.pop_front();
          in_flight         <= next_pair;
          in_ch.start_year  <= next_pair.first.year;
          in_ch.start_month <= next_pair.first.month;
          in_ch.start_day   <= next_pair.first.day;
          in_ch.end_year    <= next_pair.last.year;
          in_ch.end_month   <= next_pair.last.month;
          in_ch.end_day     <= next_pair.last.day;
          in_ch.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: the stall pattern steps through phases of a free-running
  // counter, and once the output is held off long enough for the block to back up to its input.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      rx_cycle     <= '0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
        hold_done    <= 1'b1;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          3'd0, 3'd1:       out_ch.ready <= 1'b1;
          3'd2, 3'd3, 3'd4: out_ch.ready <= ($urandom_range(0, 2) != 0);
          3'd5:             out_ch.ready <= (rx_cycle[1:0] != 2'd3);
          default:          out_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: result with no request outstanding: day_count=%0d invalid=%0b",
                 $time, out_ch.day_count, out_ch.invalid);
        n_errors++;
      end else begin
        wanted = expected_counts.pop_front();
        if (out_ch.day_count !== wanted.count || out_ch.invalid !== wanted.invalid) begin
          $display("%0t: expected day_count=%0d invalid=%0b, actual day_count=%0d invalid=%0b",
                   $time, wanted.count, wanted.invalid, out_ch.day_count, out_ch.invalid);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.start_year  = '0;
    in_ch.start_month = '0;
    in_ch.start_day   = '0;
    in_ch.end_year    = '0;
    in_ch.end_month   = '0;
    in_ch.end_day     = '0;
    out_ch.ready      = 1'b0;

    push_pair(1, 1, 1, 1, 1, 1);
    push_pair(1, 1, 1, 9999, 12, 31);
    push_pair(9999, 12, 31, 9999, 12, 31);
    push_pair(2000, 2, 29, 2000, 3, 1);
    push_pair(1900, 2, 29, 1900, 3, 1);
    push_pair(2004, 2, 29, 2004, 2, 29);
    push_pair(2023, 2, 29, 2023, 3, 1);
    push_pair(1600, 2, 28, 1600, 3, 1);
    push_pair(1700, 2, 28, 1700, 3, 1);
    push_pair(1899, 12, 31, 1900, 3, 1);
    push_pair(2020, 1, 31, 2020, 12, 31);
    push_pair(2024, 12, 31, 2025, 1, 1);
    push_pair(0, 1, 1, 1, 1, 1);
    push_pair(1, 1, 1, 10000, 1, 1);
    push_pair(16383, 15, 31, 16383, 15, 31);
    push_pair(2020, 0, 10, 2020, 5, 5);
    push_pair(2020, 1, 1, 2020, 13, 1);
    push_pair(2020, 4, 31, 2020, 5, 1);
    push_pair(2020, 6, 0, 2020, 6, 1);
    push_pair(1, 1, 1, 1, 1, 0);
    push_pair(2021, 3, 2, 2021, 3, 1);
    push_pair(9999, 12, 31, 1, 1, 1);
    for (i = 0; i < RANDOM_PAIRS; i++) pending_pairs.push_back(random_pair());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sampling on the falling edge keeps the end checks clear of the clocked blocks.
    @(negedge clk);
    while (pending_pairs.size() > 0 || in_ch.valid) @(negedge clk);
    while (expected_counts.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/idc_pkg.sv
rtl/core/idc_if.sv
rtl/core/idc_front.sv
rtl/core/idc_fifo.sv
rtl/core/idc_back.sv
rtl/core/inclusive_day_count_top.sv
tb/tb_top.sv
